@@ src/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define AST_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/apsu_pkg.sv @@
package apsu_pkg;

  localparam int MAX_PROCS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 10;
  localparam int ID_W           = 8;
  localparam int IN_CNT_W       = 10;
  localparam int OCC_W          = 4;

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_RAN   = 2'd0,
    ST_IDLE  = 2'd1,
    ST_ADDED = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_TAIL,
    S_HEAD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [IN_CNT_W-1:0] start_score;
    logic [IN_CNT_W-1:0] instr_count;
    logic [ID_W-1:0]     proc_id;
    op_t                 operation;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  ran_id;
    logic             ran_finished;
    logic [OCC_W-1:0] occupancy;
  } result_t;

endpackage

@@ src/aging_process_scheduler_unit.sv @@
// aging scheduler over an ordered process table held in a single-port-write ram
// add: appends the entry if there is room; tick: a scan drops finished entries, runs the head, ages
// the rest, then promotes the lowest-scored entry m of the k left if below the head's
// one item at a time: the input is ready again once the result is in the output register
// rst is synchronous, active high: table empties, the fsm idles, no result is held
`include "assert_macros.svh"

module aging_process_scheduler_unit #(
  parameter int MAX_PROCS  = apsu_pkg::MAX_PROCS_DEF,
  parameter int COUNT_BITS = apsu_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // proc_id[7:0], instr_count[17:8], start_score[27:18]
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // ran_id[7:0], ran_finished[8], occupancy[12:9]
  output logic [1:0]  m_axis_tuser   // status
);

  import apsu_pkg::*;

  localparam int AW = $clog2(MAX_PROCS);
  localparam int EW = ID_W + 2 * COUNT_BITS;

  item_t          item;
  result_t        res;
  result_t        res_q;
  logic           start;
  logic           ctrl_ready;
  logic           res_ready;
  logic           res_valid;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic           we;
  logic [EW-1:0]  rdata;
  logic [EW-1:0]  wdata;

  // unpack the slave beat into the item fields
  assign item.operation   = op_t'(s_axis_tuser);
  assign item.proc_id     = s_axis_tdata[7:0];
  assign item.instr_count = s_axis_tdata[17:8];
  assign item.start_score = s_axis_tdata[27:18];

  assign s_axis_tready = ctrl_ready;
  assign start         = s_axis_tvalid && ctrl_ready;

  // output register is free when empty or being drained this cycle
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  // process table: id, remaining count and score per slot
  apsu_table #(
    .DEPTH (MAX_PROCS),
    .EW    (EW)
  ) u_table (
    .clk   (clk),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  // sequencer: adds, or for a tick the compaction and ageing scan, then the promotion shuffle
  apsu_ctrl #(
    .MAX_PROCS  (MAX_PROCS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .ready     (ctrl_ready),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .raddr     (raddr),
    .rdata     (rdata),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {3'b000, res_q.occupancy, res_q.ran_finished, res_q.ran_id};
  assign m_axis_tuser = res_q.status;

  // sequencer never reports while it is waiting for an item
  `AST_IMPLY(a_no_res_when_idle, clk, rst, s_axis_tready, !res_valid,
             "result produced while idle")
  // a result is only handed over when the output register can take it
  `AST_IMPLY(a_res_into_free_slot, clk, rst, res_valid, res_ready,
             "result would overwrite a pending beat")
  // an accepted item leaves the block busy in the following cycle
  `AST_NEXT(a_busy_after_accept, clk, rst, start, !s_axis_tready,
            "ready right after accept")
  // after the result the block returns to waiting for the next item
  `AST_NEXT(a_ready_after_res, clk, rst, res_valid, s_axis_tready && m_axis_tvalid,
            "not ready after result")

endmodule

@@ src/apsu_table.sv @@
module apsu_table #(
  parameter int DEPTH = 8,
  parameter int EW    = 28
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [EW-1:0]            rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [EW-1:0]            wdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/apsu_ctrl.sv @@
module apsu_ctrl #(
  parameter int MAX_PROCS  = 8,
  parameter int COUNT_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  apsu_pkg::item_t                        item,
  output logic                                   ready,
  input  logic                                   res_ready,
  output logic                                   res_valid,
  output apsu_pkg::result_t                      res,
  output logic [$clog2(MAX_PROCS)-1:0]           raddr,
  input  logic [apsu_pkg::ID_W+2*COUNT_BITS-1:0] rdata,
  output logic                                   we,
  output logic [$clog2(MAX_PROCS)-1:0]           waddr,
  output logic [apsu_pkg::ID_W+2*COUNT_BITS-1:0] wdata
);

  import apsu_pkg::*;

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int CB = COUNT_BITS;

  state_t state, state_next;

  logic [CW-1:0]   n;
  logic [CW-1:0]   r;
  logic [CW-1:0]   w;
  logic            pv;
  logic [AW-1:0]   pa;
  logic [AW-1:0]   m;
  logic [CB-1:0]   minsc;
  logic [ID_W-1:0] hid;
  logic [CB-1:0]   hrem;
  logic [CB-1:0]   hsc;
  logic            hfin;
  logic [ID_W-1:0] mid;
  logic [CB-1:0]   mrem;
  logic [CB-1:0]   msc;

  logic [ID_W-1:0] rd_id;
  logic [CB-1:0]   rd_rem;
  logic [CB-1:0]   rd_sc;
  logic            rd_live;
  logic [CB-1:0]   rem_dec;
  logic [CB-1:0]   sc_dec;
  logic            is_head;
  logic            lower;
  logic            pass_end;
  logic            has_room;
  logic [CB-1:0]   in_rem;
  logic [CB-1:0]   in_sc;

  assign rd_id    = rdata[ID_W-1:0];
  assign rd_rem   = rdata[ID_W +: CB];
  assign rd_sc    = rdata[ID_W+CB +: CB];
  assign rd_live  = (rd_rem != '0);
  // shared unit: one count decrement, one saturating score decrement and one compare per beat
  assign rem_dec  = rd_rem - CB'(1);
  assign sc_dec   = (rd_sc == '0) ? '0 : rd_sc - CB'(1);
  assign is_head  = (w == '0);
  assign lower    = (sc_dec < minsc);
  assign pass_end = (r == n) && !pv;
  assign has_room = (n < CW'(MAX_PROCS));
  assign in_rem   = CB'(item.instr_count);
  assign in_sc    = CB'(item.start_score);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (item.operation == OP_ADD || n == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pass_end) begin
          if (w != '0 && m != '0) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        if (pass_end) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL:  state_next = S_HEAD;
      S_HEAD:  state_next = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ready     = 1'b0;
    res_valid = 1'b0;
    raddr     = r[AW-1:0];
    we        = 1'b0;
    waddr     = n[AW-1:0];
    wdata     = {in_sc, in_rem, item.proc_id};
    case (state)
      S_IDLE: begin
        ready = 1'b1;
        we    = start && (item.operation == OP_ADD) && has_room;
      end
      S_SCAN: begin
        we    = pv && rd_live;
        waddr = w[AW-1:0];
        wdata = is_head ? {rd_sc, rem_dec, rd_id} : {sc_dec, rd_rem, rd_id};
      end
      S_SHIFT: begin
        we    = pv;
        waddr = pa - AW'(1);
        wdata = rdata;
      end
      S_TAIL: begin
        we    = 1'b1;
        waddr = AW'(n - CW'(1));
        wdata = {hsc, hrem, hid};
      end
      S_HEAD: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {msc, mrem, mid};
      end
      S_DONE: begin
        res_valid = res_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            pv <= 1'b0;
            if (item.operation == OP_ADD) begin
              if (has_room) begin
                n   <= n + CW'(1);
                res <= '{ST_ADDED, '0, 1'b0, OCC_W'(n + CW'(1))};
              end else begin
                res <= '{ST_FULL, '0, 1'b0, OCC_W'(n)};
              end
            end else if (n == '0) begin
              res <= '{ST_IDLE, '0, 1'b0, '0};
            end else begin
              r <= '0;
              w <= '0;
              m <= '0;
            end
          end
        end
        S_SCAN: begin
          pv <= (r != n);
          if (r != n) begin
            r <= r + CW'(1);
          end
          if (pv && rd_live) begin
            w <= w + CW'(1);
            if (is_head) begin
              hid   <= rd_id;
              hrem  <= rem_dec;
              hsc   <= rd_sc;
              hfin  <= (rem_dec == '0);
              minsc <= rd_sc;
            end else if (lower) begin
              minsc <= sc_dec;
              m     <= w[AW-1:0];
              mid   <= rd_id;
              mrem  <= rd_rem;
              msc   <= sc_dec;
            end
          end
          if (pass_end) begin
            n <= w;
            r <= CW'(m) + CW'(1);
            if (w == '0) begin
              res <= '{ST_IDLE, '0, 1'b0, '0};
            end else begin
              res <= '{ST_RAN, hid, hfin, OCC_W'(w)};
            end
          end
        end
        S_SHIFT: begin
          pv <= (r != n);
          pa <= r[AW-1:0];
          if (r != n) begin
            r <= r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ verif/tb_aging_process_scheduler_unit.sv @@
`timescale 1ns / 1ps

module tb_aging_process_scheduler_unit;
  import apsu_pkg::*;

  localparam int PROCS        = MAX_PROCS_DEF;
  localparam int RANDOM_ITEMS = 1370;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int REPORT_MAX   = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  aging_process_scheduler_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the process table
  logic [ID_W-1:0]     tbl_id[PROCS];
  logic [IN_CNT_W-1:0] tbl_left[PROCS];
  logic [IN_CNT_W-1:0] tbl_score[PROCS];
  int                  tbl_count = 0;

  result_t pending_results[$];

  int mismatch_count = 0;
  int checked_count  = 0;
  int cycle_count    = 0;
  int n_add = 0, n_tick = 0, n_ran = 0, n_finished = 0, n_idle = 0, n_full = 0;
  int n_promoted = 0;

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_pending = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // works out the result of one item and updates the shadow table
  function automatic result_t schedule_step(input op_t op, input logic [ID_W-1:0] id,
                                            input logic [IN_CNT_W-1:0] cnt,
                                            input logic [IN_CNT_W-1:0] score);
    result_t r;
    int w, m;
    logic [ID_W-1:0] hid, mid;
    logic [IN_CNT_W-1:0] hleft, hscore, mleft, mscore;
    r = '0;
    if (op == OP_ADD) begin
      n_add++;
      if (tbl_count >= PROCS) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        tbl_id[tbl_count]    = id;
        tbl_left[tbl_count]  = cnt;
        tbl_score[tbl_count] = score;
        tbl_count++;
        r.status = ST_ADDED;
      end
    end else begin
      n_tick++;
      // drop every entry with no count left, keeping order
      w = 0;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_left[i] != '0) begin
          tbl_id[w]    = tbl_id[i];
          tbl_left[w]  = tbl_left[i];
          tbl_score[w] = tbl_score[i];
          w++;
        end
      end
      tbl_count = w;
      if (tbl_count == 0) begin
        r.status = ST_IDLE;
        n_idle++;
      end else begin
        r.status = ST_RAN;
        r.ran_id = tbl_id[0];
        tbl_left[0] = tbl_left[0] - 1'b1;
        r.ran_finished = (tbl_left[0] == '0);
        n_ran++;
        if (r.ran_finished) n_finished++;
        // age everything behind the head
        for (int i = 1; i < tbl_count; i++)
          if (tbl_score[i] != '0) tbl_score[i] = tbl_score[i] - 1'b1;
        m = 0;
        for (int i = 1; i < tbl_count; i++)
          if (tbl_score[i] < tbl_score[m]) m = i;
        if (m != 0 && tbl_score[m] < tbl_score[0]) begin
          n_promoted++;
          hid = tbl_id[0];    hleft = tbl_left[0];    hscore = tbl_score[0];
          mid = tbl_id[m];    mleft = tbl_left[m];    mscore = tbl_score[m];
          for (int i = m; i + 1 < tbl_count; i++) begin
            tbl_id[i]    = tbl_id[i + 1];
            tbl_left[i]  = tbl_left[i + 1];
            tbl_score[i] = tbl_score[i + 1];
          end
          tbl_id[0] = mid;    tbl_left[0] = mleft;    tbl_score[0] = mscore;
          tbl_id[tbl_count - 1]    = hid;
          tbl_left[tbl_count - 1]  = hleft;
          tbl_score[tbl_count - 1] = hscore;
        end
      end
    end
    r.occupancy = tbl_count[OCC_W-1:0];
    return r;
  endfunction

  // offers one beat, optionally after a gap, and records its result on acceptance
  task automatic send_item(input op_t op, input logic [ID_W-1:0] id,
                           input logic [IN_CNT_W-1:0] cnt, input logic [IN_CNT_W-1:0] score);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, score, cnt, id};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(schedule_step(op, id, cnt, score));
  endtask

  // random item; add_pct sets how often it is an add
  task automatic send_random(input int add_pct);
    op_t op;
    logic [IN_CNT_W-1:0] cnt, score;
    int r;
    op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
    r = $urandom_range(0, 99);
    if (r < 3)       cnt = '0;
    else if (r < 70) cnt = IN_CNT_W'($urandom_range(1, 4));
    else if (r < 95) cnt = IN_CNT_W'($urandom_range(5, 20));
    else             cnt = IN_CNT_W'($urandom_range(21, 60));
    // low scores make ties and promotions common
    score = ($urandom_range(0, 1) == 0) ? IN_CNT_W'($urandom_range(0, 15))
                                        : IN_CNT_W'($urandom_range(0, 1023));
    send_item(op, ID_W'($urandom_range(0, 255)), cnt, score);
  endtask

  // output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compares every accepted result beat with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: result beat with nothing expected: status %0d tdata %h",
                   $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (m_axis_tuser != want.status || m_axis_tdata[7:0] != want.ran_id ||
            m_axis_tdata[8] != want.ran_finished || m_axis_tdata[12:9] != want.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: mismatch on result %0d: expected status %0d id %0d fin %0d occ %0d",
                     $time, checked_count, want.status, want.ran_id, want.ran_finished,
                     want.occupancy);
            $display("  got status %0d id %0d fin %0d occ %0d",
                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[12:9]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // extremes of every field, idle, full table, zero count, duplicate ids, promotion
  task automatic test_directed();
    send_item(OP_TICK, 8'h00, 10'd0, 10'd0);
    send_item(OP_ADD, 8'h00, 10'd1, 10'd0);
    send_item(OP_ADD, 8'hFF, 10'd2, 10'd1023);
    send_item(OP_ADD, 8'hAA, 10'd0, 10'd5);
    send_item(OP_ADD, 8'h55, 10'd3, 10'd512);
    send_item(OP_ADD, 8'hFF, 10'd1, 10'd1);
    send_item(OP_ADD, 8'h01, 10'd2, 10'd1023);
    send_item(OP_ADD, 8'h80, 10'd1, 10'd0);
    send_item(OP_ADD, 8'h7F, 10'd2, 10'd700);
    send_item(OP_ADD, 8'h11, 10'd1023, 10'd1023);
    send_item(OP_ADD, 8'hEE, 10'h155, 10'h2AA);
    repeat (14) send_item(OP_TICK, 8'h00, 10'd0, 10'd0);
  endtask

  // output held off while the input keeps offering beats
  task automatic test_output_hold();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_pending = 1'b1;
    repeat (12) send_random(60);
  endtask

  // randomly chosen fill and drain phases with changing idling on both sides
  task automatic test_random();
    int sent, phase_len, add_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 40);
      add_pct   = ($urandom_range(0, 1) == 0) ? 70 : 15;
      tx_idle   = $urandom_range(0, 2) != 0;
      rx_idle   = $urandom_range(0, 2) != 0;
      repeat (phase_len) begin
        send_random(add_pct);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_output_hold();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d adds (%0d into a full table) and %0d ticks (%0d idle)",
             n_add, n_full, n_tick, n_idle);
    $display("%0d processes run, %0d finished, %0d promotions, %0d results checked",
             n_ran, n_finished, n_promoted, checked_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
